@@ hw/rtl/tncc_pkg.sv @@
// shared types, constants and byte conversion functions for the newline and case converter
package tncc_pkg;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_QMARK = 8'd63;
    localparam logic [7:0] CASE_DIST = 8'd32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        NL_KEEP,
        NL_TO_LF,
        NL_TO_CRLF,
        NL_TO_CR
    } t_nl_mode;

    typedef enum logic [1:0] {
        CASE_KEEP,
        CASE_UPPER,
        CASE_LOWER,
        CASE_TITLE
    } t_case_mode;

    typedef enum logic [1:0] {
        NL_PAIR,
        NL_LONE_CR,
        NL_LONE_LF
    } t_nl_kind;

    typedef enum logic [1:0] {
        CFG_NEWLINE,
        CFG_CASE,
        CFG_ASCII
    } t_cfg_idx;

    typedef struct packed {
        t_nl_mode   nl_mode;
        t_case_mode case_mode;
        logic       ascii_en;
    } t_cfg;

    // one request worth of raw bytes, before case and ascii handling
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last;
        logic            chg;
        logic            fin;
    } t_plan;

    typedef struct packed {
        logic [1:0] len;
        logic [7:0] b0;
        logic [7:0] b1;
        logic       chg;
    } t_nl_seq;

    typedef struct packed {
        logic [7:0] c;
        logic       ws;
        logic       chg;
    } t_case_res;

    function automatic t_nl_seq nl_seq(input t_nl_mode mode, input t_nl_kind kind);
        t_nl_seq s;
        s.len = 2'd1;
        s.b0  = CH_LF;
        s.b1  = CH_LF;
        s.chg = 1'b0;
        case (mode)
            NL_TO_LF: begin
                s.b0  = CH_LF;
                s.chg = (kind != NL_LONE_LF);
            end
            NL_TO_CRLF: begin
                s.len = 2'd2;
                s.b0  = CH_CR;
                s.chg = (kind != NL_PAIR);
            end
            NL_TO_CR: begin
                s.b0  = CH_CR;
                s.chg = (kind != NL_LONE_CR);
            end
            default: begin
                case (kind)
                    NL_PAIR: begin
                        s.len = 2'd2;
                        s.b0  = CH_CR;
                    end
                    NL_LONE_CR: s.b0 = CH_CR;
                    default:    s.b0 = CH_LF;
                endcase
            end
        endcase
        return s;
    endfunction

    function automatic t_case_res case_byte(input logic [7:0] c, input t_case_mode mode,
                                            input logic ws);
        t_case_res r;
        logic      lo;
        logic      up;
        lo    = (c >= 8'h61) && (c <= 8'h7a);
        up    = (c >= 8'h41) && (c <= 8'h5a);
        r.c   = c;
        r.ws  = ws;
        r.chg = 1'b0;
        case (mode)
            CASE_UPPER: begin
                if (lo) begin
                    r.c   = c - CASE_DIST;
                    r.chg = 1'b1;
                end
            end
            CASE_LOWER: begin
                if (up) begin
                    r.c   = c + CASE_DIST;
                    r.chg = 1'b1;
                end
            end
            CASE_TITLE: begin
                if (lo && ws) begin
                    r.c   = c - CASE_DIST;
                    r.ws  = 1'b0;
                    r.chg = 1'b1;
                end else if (up && !ws) begin
                    r.c   = c + CASE_DIST;
                    r.chg = 1'b1;
                end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
                    r.ws = 1'b1;
                end else begin
                    r.ws = 1'b0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/tncc_front.sv @@
// front end: takes input requests, resolves newlines and held carriage returns into a byte plan
module tncc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tncc_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_in_byte,
    input  logic            i_is_final,
    input  logic            i_q_full,
    output logic            o_push,
    output tncc_pkg::t_plan o_plan
);
    import tncc_pkg::*;

    logic       r_held_cr;
    logic       n_held_cr;
    logic       active;
    logic       is_cr;
    logic       is_lf;
    logic       consumed;
    t_nl_seq    seq_a;
    t_nl_seq    seq_b;
    logic [1:0] len_a;
    logic [1:0] len_b;
    logic [2:0] len_all;
    logic       accept;

    assign active   = (i_cfg.nl_mode != NL_KEEP);
    assign is_cr    = (i_in_byte == CH_CR);
    assign is_lf    = (i_in_byte == CH_LF);
    assign consumed = r_held_cr && active && is_lf;
    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;

    always_comb begin
        seq_a     = nl_seq(i_cfg.nl_mode, consumed ? NL_PAIR : NL_LONE_CR);
        len_a     = r_held_cr ? seq_a.len : 2'd0;
        seq_b     = nl_seq(i_cfg.nl_mode, NL_LONE_LF);
        len_b     = 2'd0;
        n_held_cr = 1'b0;
        if (!consumed) begin
            if (active && is_cr) begin
                if (i_is_final) begin
                    seq_b = nl_seq(i_cfg.nl_mode, NL_LONE_CR);
                    len_b = seq_b.len;
                end else begin
                    n_held_cr = 1'b1;
                end
            end else if (active && is_lf) begin
                len_b = seq_b.len;
            end else begin
                seq_b.b0  = i_in_byte;
                seq_b.chg = 1'b0;
                len_b     = 2'd1;
            end
        end
        len_all = {1'b0, len_a} + {1'b0, len_b};

        o_plan.bytes[0] = (len_a == 2'd0) ? seq_b.b0 : seq_a.b0;
        o_plan.bytes[1] = (len_a == 2'd0) ? seq_b.b1 :
                          (len_a == 2'd1) ? seq_b.b0 : seq_a.b1;
        o_plan.bytes[2] = (len_a == 2'd2) ? seq_b.b0 : seq_b.b1;
        o_plan.bytes[3] = seq_b.b1;
        o_plan.last     = 2'(len_all - 3'd1);
        o_plan.chg      = (r_held_cr && seq_a.chg) || ((len_b != 2'd0) && seq_b.chg);
        o_plan.fin      = i_is_final;
        o_push          = accept && (len_all != 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cr <= 1'b0;
        end else if (accept) begin
            r_held_cr <= n_held_cr;
        end
    end

`ifndef SYNTHESIS
    // a held carriage return is never carried past the end of a file
    a_no_hold_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_is_final |=> !r_held_cr)
        else $error("carriage return held across end of file");
    // a final byte always produces results
    a_final_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_is_final |-> o_push)
        else $error("final byte produced no result");
    // a request that yields nothing must leave a carriage return held
    a_empty_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !o_push |=> r_held_cr)
        else $error("request dropped without holding");
`endif

endmodule

@@ hw/rtl/tncc_queue.sv @@
// short plan queue between front and back
module tncc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tncc_pkg::t_plan i_plan,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_head_valid,
    output tncc_pkg::t_plan o_head
);
    import tncc_pkg::*;

    t_plan             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_pop;
    logic              do_push;

    assign o_full       = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rp];
    assign do_pop       = i_pop && o_head_valid;
    assign do_push      = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_plan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("pop from empty queue");
`endif

endmodule

@@ hw/rtl/tncc_back.sv @@
// back end: walks plans a byte per unstalled cycle, applies case/ascii rules, drives output regs
module tncc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tncc_pkg::t_cfg  i_cfg,
    input  logic            i_head_valid,
    input  tncc_pkg::t_plan i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_run_end,
    output logic            o_file_end,
    output logic            o_any_change
);
    import tncc_pkg::*;

    logic       r_valid;
    logic [7:0] r_out_byte;
    logic       r_run_end;
    logic       r_file_end;
    logic       r_any_change;
    logic [1:0] r_idx;
    logic       r_word_start;
    logic       r_changed;
    logic       advance;
    logic       last;
    logic       fend;
    logic       ascii_hit;
    logic       chg_now;
    logic [7:0] n_byte;
    t_case_res  cres;

    assign advance = i_head_valid && (!r_valid || i_ready);
    assign last    = (r_idx == i_head.last);
    assign fend    = last && i_head.fin;
    assign o_pop   = advance && last;

    always_comb begin
        cres      = case_byte(i_head.bytes[r_idx], i_cfg.case_mode, r_word_start);
        ascii_hit = i_cfg.ascii_en && cres.c[7];
        n_byte    = ascii_hit ? CH_QMARK : cres.c;
        chg_now   = r_changed || i_head.chg || cres.chg || ascii_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_idx        <= 2'd0;
            r_word_start <= 1'b1;
            r_changed    <= 1'b0;
        end else begin
            if (advance) begin
                r_valid      <= 1'b1;
                r_idx        <= last ? 2'd0 : r_idx + 2'd1;
                r_word_start <= fend ? 1'b1 : cres.ws;
                r_changed    <= fend ? 1'b0 : chg_now;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte   <= n_byte;
            r_run_end    <= last;
            r_file_end   <= fend;
            r_any_change <= fend && chg_now;
        end
    end

    assign o_valid      = r_valid;
    assign o_out_byte   = r_out_byte;
    assign o_run_end    = r_run_end;
    assign o_file_end   = r_file_end;
    assign o_any_change = r_any_change;

`ifndef SYNTHESIS
    // byte index stays inside the current plan
    a_idx_in_plan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> r_idx <= i_head.last)
        else $error("byte index beyond plan");
    a_fend_is_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_file_end |-> r_run_end)
        else $error("file end without run end");
    a_change_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_any_change |-> r_file_end)
        else $error("change flag outside file end");
    // file state is back at its start after the last byte of a file
    a_file_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && fend |=> r_word_start && !r_changed && r_idx == 2'd0)
        else $error("file state not cleared");
`endif

endmodule

@@ hw/rtl/text_newline_case_converter.sv @@
// top level: newline, case and ascii conversion of a byte stream
// a request's first result passes the plan queue, then the back end output register
// throughput: one result per cycle while the output is not stalled; a request yields
// 0 to 4 results and holds the byte walker in the back end until its last is produced
// a two-entry plan queue lets the front take requests while the back is stalled
// reset (synchronous, active low) clears registers to mode 0, queue and output to empty
module text_newline_case_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [1:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_final,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_end,
    output logic       o_file_end,
    output logic       o_any_change
);
    import tncc_pkg::*;

    t_cfg  r_cfg;
    t_plan plan;
    t_plan head;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nl_mode   <= NL_KEEP;
            r_cfg.case_mode <= CASE_KEEP;
            r_cfg.ascii_en  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NEWLINE: r_cfg.nl_mode   <= t_nl_mode'(i_cfg_data);
                CFG_CASE:    r_cfg.case_mode <= t_case_mode'(i_cfg_data);
                CFG_ASCII:   r_cfg.ascii_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tncc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_byte  (i_in_byte),
        .i_is_final (i_is_final),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_plan     (plan)
    );

    tncc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_plan       (plan),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    tncc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_run_end    (o_run_end),
        .o_file_end   (o_file_end),
        .o_any_change (o_any_change)
    );

endmodule
